>>> rtl/core/vpisc_pkg.sv
// ---------------------------------------------------------------------------
// vpisc_pkg
// Shared types and codes for the velocity PI servo controller.
// ---------------------------------------------------------------------------
package vpisc_pkg;

	typedef enum logic [1:0] {
		MODE_LOOP   = 2'd0,
		MODE_MANUAL = 2'd1,
		MODE_HOLD   = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_INTEG_PERIOD = 3'd2,
		REG_FWD_START    = 3'd3,
		REG_REV_START    = 3'd4,
		REG_NEUTRAL      = 3'd5,
		REG_PULSE_MAX    = 3'd6,
		REG_PULSE_MIN    = 3'd7
	} reg_idx_t;

	localparam int AddrW = 5;
	localparam int DataW = 32;

	typedef struct packed {
		logic        [7:0]  prop_gain;
		logic        [7:0]  integ_gain;
		logic        [7:0]  integ_reset_period;
		logic        [9:0]  fwd_start;
		logic signed [10:0] rev_start;
		logic        [11:0] neutral_pulse;
		logic        [11:0] pulse_max;
		logic        [11:0] pulse_min;
	} cfg_t;

	// one control tick after the front stage
	typedef struct packed {
		logic signed [16:0] err;
		logic signed [31:0] isum;
		logic signed [11:0] start;
		logic               pass;
		logic        [1:0]  mode;
		logic        [11:0] manual;
	} tick_t;

endpackage

>>> rtl/core/velocity_pi_servo_controller.sv
// ---------------------------------------------------------------------------
// velocity_pi_servo_controller
// Velocity PI loop with start offset, dead zone and output clamp.
//
// Input channel (in_valid/in_ready) takes one control tick per word: target
// and measured velocity in signed Q(FRAC_BITS), mode and manual pulse.
// Output channel (out_valid/out_ready) delivers pulse_us in microseconds.
// Closed-loop and manual ticks give one word; hold ticks and code 3 give none.
// Throughput is one tick per cycle while out_ready is high, set by the
// input register feeding the two parallel multiplies and the clamp ahead
// of the output register, which takes each word from the input register.
// Integral sum and tick counter advance on every accepted tick.
// When out_ready is low the output register holds its word; one more tick
// is taken into the input register, then in_ready drops until it drains.
// Reset clears the integral state, both pipeline valids, and loads the
// register defaults. The APB port writes in the access phase, pready = 1.
// ---------------------------------------------------------------------------
module velocity_pi_servo_controller #(
	parameter int FRAC_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vpisc_pkg::AddrW-1:0] paddr,
	input  logic [vpisc_pkg::DataW-1:0] pwdata,
	output logic [vpisc_pkg::DataW-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [15:0]          target_vel,
	input  logic signed [15:0]          measured_vel,
	input  logic [1:0]                  mode,
	input  logic [11:0]                 manual_pulse,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [11:0]                 pulse_us
);
	import vpisc_pkg::*;

	cfg_t  cfg;
	tick_t tick_s1;
	logic  valid_s1;
	logic  adv;

	vpisc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vpisc_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.target_vel   (target_vel),
		.measured_vel (measured_vel),
		.mode         (mode),
		.manual_pulse (manual_pulse),
		.cfg          (cfg),
		.adv          (adv),
		.valid_s1     (valid_s1),
		.tick_s1      (tick_s1)
	);

	vpisc_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.tick_s1   (tick_s1),
		.cfg       (cfg),
		.adv       (adv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pulse_us  (pulse_us)
	);

endmodule

>>> rtl/core/vpisc_cfg.sv
// ---------------------------------------------------------------------------
// vpisc_cfg
// APB-style register file holding gains, offsets and pulse limits.
// ---------------------------------------------------------------------------
module vpisc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vpisc_pkg::AddrW-1:0] paddr,
	input  logic [vpisc_pkg::DataW-1:0] pwdata,
	output logic [vpisc_pkg::DataW-1:0] prdata,
	output logic                        pready,
	output vpisc_pkg::cfg_t             cfg
);
	import vpisc_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain          <= 8'd70;
			cfg_q.integ_gain         <= 8'd5;
			cfg_q.integ_reset_period <= 8'd20;
			cfg_q.fwd_start          <= 10'd225;
			cfg_q.rev_start          <= -11'sd200;
			cfg_q.neutral_pulse      <= 12'd1550;
			cfg_q.pulse_max          <= 12'd2100;
			cfg_q.pulse_min          <= 12'd1200;
		end else if (wr_en) begin
			unique case (idx)
				REG_PROP_GAIN:    cfg_q.prop_gain          <= pwdata[7:0];
				REG_INTEG_GAIN:   cfg_q.integ_gain         <= pwdata[7:0];
				REG_INTEG_PERIOD: cfg_q.integ_reset_period <= pwdata[7:0];
				REG_FWD_START:    cfg_q.fwd_start          <= pwdata[9:0];
				REG_REV_START:    cfg_q.rev_start          <= $signed(pwdata[10:0]);
				REG_NEUTRAL:      cfg_q.neutral_pulse      <= pwdata[11:0];
				REG_PULSE_MAX:    cfg_q.pulse_max          <= pwdata[11:0];
				REG_PULSE_MIN:    cfg_q.pulse_min          <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PROP_GAIN:    prdata = DataW'(cfg_q.prop_gain);
			REG_INTEG_GAIN:   prdata = DataW'(cfg_q.integ_gain);
			REG_INTEG_PERIOD: prdata = DataW'(cfg_q.integ_reset_period);
			REG_FWD_START:    prdata = DataW'(cfg_q.fwd_start);
			REG_REV_START:    prdata = DataW'(cfg_q.rev_start);
			REG_NEUTRAL:      prdata = DataW'(cfg_q.neutral_pulse);
			REG_PULSE_MAX:    prdata = DataW'(cfg_q.pulse_max);
			REG_PULSE_MIN:    prdata = DataW'(cfg_q.pulse_min);
			default:          prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/vpisc_front.sv
// ---------------------------------------------------------------------------
// vpisc_front
// Input register: error, integral update, start offset and dead zone flag.
// ---------------------------------------------------------------------------
module vpisc_front #(
	parameter int FRAC_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] target_vel,
	input  logic signed [15:0] measured_vel,
	input  logic [1:0]         mode,
	input  logic [11:0]        manual_pulse,
	input  vpisc_pkg::cfg_t    cfg,
	input  logic               adv,
	output logic               valid_s1,
	output vpisc_pkg::tick_t   tick_s1
);
	import vpisc_pkg::*;

	localparam logic signed [21:0] OneT = 22'(1 << FRAC_BITS);
	localparam logic [23:0]        OneE = 24'(1 << FRAC_BITS);

	logic               take;
	logic signed [16:0] err;
	logic        [16:0] aerr;
	logic signed [21:0] t20;
	logic signed [11:0] start;
	logic signed [31:0] isum;
	logic        [8:0]  cnt_nxt;
	logic               wrap;
	logic signed [31:0] integ_sum_q;
	logic        [7:0]  tick_count_q;

	assign in_ready = !valid_s1 || adv;
	assign take     = in_valid && in_ready;

	assign err  = 17'(target_vel) - 17'(measured_vel);
	assign aerr = err[16] ? 17'(-err) : 17'(err);
	assign t20  = (22'(target_vel) <<< 4) + (22'(target_vel) <<< 2);
	assign isum = integ_sum_q + 32'(err);

	assign cnt_nxt = {1'b0, tick_count_q} + 9'd1;
	assign wrap    = cnt_nxt > {1'b0, cfg.integ_reset_period};

	always_comb begin
		priority if (t20 > OneT)
			start = $signed({2'b00, cfg.fwd_start});
		else if (t20 < -OneT)
			start = 12'(cfg.rev_start);
		else
			start = 12'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			integ_sum_q  <= '0;
			tick_count_q <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (take) begin
				integ_sum_q  <= wrap ? 32'sd0 : isum;
				tick_count_q <= wrap ? 8'd0 : cnt_nxt[7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tick_s1.err    <= err;
			tick_s1.isum   <= isum;
			tick_s1.start  <= start;
			tick_s1.pass   <= (24'(aerr) * 24'd100) > OneE;
			tick_s1.mode   <= mode;
			tick_s1.manual <= manual_pulse;
		end
	end

endmodule

>>> rtl/core/vpisc_back.sv
// ---------------------------------------------------------------------------
// vpisc_back
// PI terms, pulse sum, clamp, mode select and the output register.
// ---------------------------------------------------------------------------
module vpisc_back #(
	parameter int FRAC_BITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  vpisc_pkg::tick_t tick_s1,
	input  vpisc_pkg::cfg_t  cfg,
	output logic             adv,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [11:0]      pulse_us
);
	import vpisc_pkg::*;

	localparam logic signed [40:0] RndI = 41'((1 << FRAC_BITS) - 1);
	localparam logic signed [24:0] RndP = 25'((1 << FRAC_BITS) - 1);

	logic signed [40:0] iprod;
	logic signed [40:0] iadj;
	logic signed [40:0] iterm;
	logic signed [24:0] pprod;
	logic signed [24:0] padj;
	logic signed [24:0] pterm;
	logic signed [41:0] sum;
	logic        [11:0] clamped;
	logic        [11:0] res;
	logic               emit;
	logic               out_valid_q;
	logic        [11:0] pulse_q;

	assign iprod = 41'(tick_s1.isum) * 41'($signed({1'b0, cfg.integ_gain}));
	assign iadj  = iprod + (iprod[40] ? RndI : 41'sd0);
	assign iterm = iadj >>> FRAC_BITS;

	assign pprod = 25'(tick_s1.err) * 25'($signed({1'b0, cfg.prop_gain}));
	assign padj  = pprod + (pprod[24] ? RndP : 25'sd0);
	assign pterm = padj >>> FRAC_BITS;

	assign sum = 42'($signed({1'b0, cfg.neutral_pulse})) + 42'(tick_s1.start)
	           + 42'(iterm) + 42'(pterm);

	always_comb begin
		priority if (sum > $signed({30'd0, cfg.pulse_max}))
			clamped = cfg.pulse_max;
		else if (sum < $signed({30'd0, cfg.pulse_min}))
			clamped = cfg.pulse_min;
		else
			clamped = sum[11:0];
	end

	always_comb begin
		unique case (tick_s1.mode)
			MODE_LOOP: begin
				emit = 1'b1;
				res  = tick_s1.pass ? clamped : cfg.neutral_pulse;
			end
			MODE_MANUAL: begin
				emit = 1'b1;
				res  = tick_s1.manual;
			end
			default: begin
				emit = 1'b0;
				res  = tick_s1.manual;
			end
		endcase
	end

	assign adv       = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign pulse_us  = pulse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && emit)
			pulse_q <= res;
	end

endmodule
